// ----- rtl/dbrt_pkg.sv -----
// Shared types, constants and helper functions for the dirty byte run tracker.
// No dependencies; every other file refers to it by scoped names.
package dbrt_pkg;

    localparam int COL_W        = 8;
    localparam int PAGE_W       = 4;
    localparam int KIND_W       = 2;
    localparam int COORD_W      = 8;
    localparam int RUN_START_W  = 10;
    localparam int RUN_LENGTH_W = 11;
    localparam int PROD_W       = 12;
    localparam int MPOS_W       = 17;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;

    localparam logic [7:0] MAP_ONES = 8'hFF;
    localparam logic [7:0] MAP_ZERO = 8'h00;
    localparam logic [7:0] BIT_ONE  = 8'h01;

    localparam logic [COL_W-1:0]  COLUMNS_RESET = 8'd128;
    localparam logic [PAGE_W-1:0] PAGES_RESET   = 4'd8;

    // register index, taken from paddr[2]
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_PAGES   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_FETCH = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK_CALC,
        ST_MARK_READ,
        ST_MARK_WRITE,
        ST_FETCH_INIT,
        ST_SCAN_READ,
        ST_SCAN_EVAL,
        ST_FETCH_DONE
    } t_state;

    typedef struct packed {
        logic [COL_W-1:0]  columns;
        logic [PAGE_W-1:0] pages;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic mark_calc;
        logic mark_read;
        logic mark_write;
        logic fetch_init;
        logic scan_read;
        logic scan_eval;
        logic clear_map;
    } t_cmd;

    typedef struct packed {
        logic past_end;
        logic run_end;
        logic exhausted;
    } t_status;

    // lowest set bit index of an 8-bit vector
    function automatic logic [2:0] first_one(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // bits at index p and above
    function automatic logic [7:0] ge_mask(input logic [2:0] p);
        return MAP_ONES << p;
    endfunction

endpackage

// ----- rtl/dbrt_regs.sv -----
// APB-style configuration registers: display width in columns and height in pages.
// Depends on dbrt_pkg.
module dbrt_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbrt_pkg::APB_AW-1:0]   paddr,
    input  logic [dbrt_pkg::APB_DW-1:0]   pwdata,
    output logic [dbrt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output dbrt_pkg::t_cfg                o_cfg
);

    logic [dbrt_pkg::COL_W-1:0]  r_columns;
    logic [dbrt_pkg::PAGE_W-1:0] r_pages;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= dbrt_pkg::COLUMNS_RESET;
            r_pages   <= dbrt_pkg::PAGES_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                dbrt_pkg::REG_COLUMNS: r_columns <= pwdata[dbrt_pkg::COL_W-1:0];
                dbrt_pkg::REG_PAGES:   r_pages   <= pwdata[dbrt_pkg::PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dbrt_pkg::REG_COLUMNS: prdata = dbrt_pkg::APB_DW'(r_columns);
            dbrt_pkg::REG_PAGES:   prdata = dbrt_pkg::APB_DW'(r_pages);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.columns            = r_columns;
    assign o_cfg.pages              = r_pages;

endmodule

// ----- rtl/dbrt_ctrl.sv -----
// Controller state machine: sequences mark and fetch items over the datapath.
// Depends on dbrt_pkg.
module dbrt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [dbrt_pkg::KIND_W-1:0]   i_kind,
    input  dbrt_pkg::t_status             i_status,
    output logic                          busy,
    output dbrt_pkg::t_cmd                o_cmd
);

    dbrt_pkg::t_state r_state;
    dbrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dbrt_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_kind)
                        dbrt_pkg::KIND_BYTE,
                        dbrt_pkg::KIND_PIXEL: n_state = dbrt_pkg::ST_MARK_CALC;
                        dbrt_pkg::KIND_FETCH: n_state = dbrt_pkg::ST_FETCH_INIT;
                        default:              n_state = dbrt_pkg::ST_IDLE;
                    endcase
                end
            end
            dbrt_pkg::ST_MARK_CALC:  n_state = dbrt_pkg::ST_MARK_READ;
            dbrt_pkg::ST_MARK_READ:  n_state = dbrt_pkg::ST_MARK_WRITE;
            dbrt_pkg::ST_MARK_WRITE: n_state = dbrt_pkg::ST_IDLE;
            dbrt_pkg::ST_FETCH_INIT: begin
                n_state = i_status.past_end ? dbrt_pkg::ST_FETCH_DONE
                                            : dbrt_pkg::ST_SCAN_READ;
            end
            dbrt_pkg::ST_SCAN_READ:  n_state = dbrt_pkg::ST_SCAN_EVAL;
            dbrt_pkg::ST_SCAN_EVAL: begin
                if (i_status.run_end) begin
                    n_state = dbrt_pkg::ST_IDLE;
                end else if (i_status.exhausted) begin
                    n_state = dbrt_pkg::ST_FETCH_DONE;
                end else begin
                    n_state = dbrt_pkg::ST_SCAN_READ;
                end
            end
            dbrt_pkg::ST_FETCH_DONE: n_state = dbrt_pkg::ST_IDLE;
            default:                 n_state = dbrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            dbrt_pkg::ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            dbrt_pkg::ST_MARK_CALC:  o_cmd.mark_calc  = 1'b1;
            dbrt_pkg::ST_MARK_READ:  o_cmd.mark_read  = 1'b1;
            dbrt_pkg::ST_MARK_WRITE: o_cmd.mark_write = 1'b1;
            dbrt_pkg::ST_FETCH_INIT: o_cmd.fetch_init = 1'b1;
            dbrt_pkg::ST_SCAN_READ:  o_cmd.scan_read  = 1'b1;
            dbrt_pkg::ST_SCAN_EVAL:  o_cmd.scan_eval  = 1'b1;
            dbrt_pkg::ST_FETCH_DONE: o_cmd.clear_map  = 1'b1;
            default:                 busy             = 1'b1;
        endcase
    end

    // an evaluation always follows the read that feeds it
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dbrt_pkg::ST_SCAN_EVAL |-> $past(r_state) == dbrt_pkg::ST_SCAN_READ)
        else $error("scan evaluation without a preceding read");

endmodule

// ----- rtl/dbrt_datapath.sv -----
// Datapath: dirty map memory with per-word valid bits, mark offset unit,
// run scanner over 8-bit map words, cursor and result registers. Depends on dbrt_pkg.
module dbrt_datapath #(
    parameter int MAX_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dbrt_pkg::t_cmd                      i_cmd,
    input  dbrt_pkg::t_cfg                      i_cfg,
    input  logic [dbrt_pkg::KIND_W-1:0]         i_kind,
    input  logic [dbrt_pkg::COORD_W-1:0]        i_x_coord,
    input  logic [dbrt_pkg::COORD_W-1:0]        i_y_coord,
    output dbrt_pkg::t_status                   o_status,
    output logic                                o_valid,
    output logic [dbrt_pkg::RUN_START_W-1:0]    o_run_start,
    output logic [dbrt_pkg::RUN_LENGTH_W-1:0]   o_run_length,
    output logic                                o_done_res
);

    localparam int MAP_WORDS = (MAX_BYTES + 7) / 8;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = $clog2(MAX_BYTES + 1);

    // captured item
    logic [dbrt_pkg::KIND_W-1:0]  r_kind;
    logic [dbrt_pkg::COORD_W-1:0] r_x;
    logic [dbrt_pkg::COORD_W-1:0] r_y;

    logic [POS_W-1:0]  r_size;
    logic [POS_W-1:0]  n_size;
    logic [dbrt_pkg::PROD_W-1:0] prod;

    // mark path
    logic [dbrt_pkg::MPOS_W-1:0] r_mpos;
    logic                        r_mok;
    logic                        r_hit;
    logic [dbrt_pkg::COORD_W-1:0] row;
    logic [dbrt_pkg::MPOS_W-1:0] n_mpos;
    logic                        n_mok;
    logic [WORD_W-1:0]           mark_addr;

    // map memory
    logic [7:0]           r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_valid_bits;
    logic                 r_default;
    logic [7:0]           r_rdata;
    logic                 r_rvalid;
    logic [WORD_W-1:0]    rd_addr;
    logic [7:0]           word;

    // scanner
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_start;
    logic             r_in_run;
    logic [POS_W-1:0] r_cursor;
    logic [POS_W-1:0] base;
    logic [POS_W:0]   next;
    logic             next_ge;
    logic [7:0]       inrange;
    logic [7:0]       seek_vec;
    logic [7:0]       stop_vec;
    logic             found_s;
    logic             found_k;
    logic [2:0]       s_idx;
    logic [2:0]       k_idx;
    logic [POS_W-1:0] run_start_pos;
    logic [POS_W-1:0] end_pos;

    // results
    logic                                r_out_valid;
    logic [dbrt_pkg::RUN_START_W-1:0]    r_run_start;
    logic [dbrt_pkg::RUN_LENGTH_W-1:0]   r_run_length;
    logic                                r_done;

    // screen size, capped at the map size
    always_comb begin
        prod = dbrt_pkg::PROD_W'(i_cfg.columns) * dbrt_pkg::PROD_W'(i_cfg.pages);
        if (32'(prod) > 32'(MAX_BYTES)) begin
            n_size = POS_W'(MAX_BYTES);
        end else begin
            n_size = POS_W'(prod);
        end
    end

    // mark offset and on-screen check
    always_comb begin
        if (r_kind == dbrt_pkg::KIND_PIXEL) begin
            row   = {3'b000, r_y[7:3]};
            n_mok = (r_x < i_cfg.columns) &&
                    (r_y < dbrt_pkg::COORD_W'({i_cfg.pages, 3'b000}));
        end else begin
            row   = r_y;
            n_mok = (r_x < i_cfg.columns) && (r_y < dbrt_pkg::COORD_W'(i_cfg.pages));
        end
        n_mpos = dbrt_pkg::MPOS_W'(16'(row) * 16'(i_cfg.columns))
               + dbrt_pkg::MPOS_W'(r_x);
    end

    assign mark_addr = WORD_W'(r_mpos >> 3);
    assign rd_addr   = i_cmd.mark_read ? mark_addr : WORD_W'(r_pos >> 3);
    assign word      = r_rvalid ? r_rdata : (r_default ? dbrt_pkg::MAP_ONES
                                                       : dbrt_pkg::MAP_ZERO);

    // one map word per evaluation: find the run start, then the first clean
    // or off-screen bit at or after it
    always_comb begin
        base = {r_pos[POS_W-1:3], 3'b000};
        next = {1'b0, base} + (POS_W+1)'(8);
        next_ge = next >= {1'b0, r_size};
        for (int i = 0; i < 8; i++) begin
            inrange[i] = ({1'b0, base} + (POS_W+1)'(i)) < {1'b0, r_size};
        end
        seek_vec = word & inrange & dbrt_pkg::ge_mask(r_pos[2:0]);
        found_s  = r_in_run || (|seek_vec);
        s_idx    = r_in_run ? r_pos[2:0] : dbrt_pkg::first_one(seek_vec);
        stop_vec = (~word | ~inrange) & dbrt_pkg::ge_mask(s_idx);
        found_k  = |stop_vec;
        k_idx    = dbrt_pkg::first_one(stop_vec);
        run_start_pos = r_in_run ? r_start : (base + POS_W'(s_idx));
        end_pos       = found_k ? (base + POS_W'(k_idx)) : r_size;
    end

    assign o_status.past_end  = r_cursor >= r_size;
    assign o_status.run_end   = found_s && (found_k || next_ge);
    assign o_status.exhausted = !found_s && next_ge;

    // map memory: registered read, read-modify-write for marks
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_read || i_cmd.scan_read) begin
            r_rdata  <= r_mem[rd_addr];
            r_rvalid <= r_valid_bits[rd_addr];
        end
        if (i_cmd.mark_write && r_hit) begin
            r_mem[mark_addr] <= word | (dbrt_pkg::BIT_ONE << r_mpos[2:0]);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= '0;
            r_default    <= 1'b1;
            r_cursor     <= '0;
            r_in_run     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cmd.mark_write && r_hit) begin
                r_valid_bits[mark_addr] <= 1'b1;
            end
            if (i_cmd.fetch_init) begin
                r_in_run <= 1'b0;
            end
            if (i_cmd.scan_eval) begin
                if (o_status.run_end) begin
                    r_cursor    <= end_pos;
                    r_out_valid <= 1'b1;
                end else if (found_s) begin
                    r_in_run <= 1'b1;
                end
            end
            // done: the whole map reads clean, rewind
            if (i_cmd.clear_map) begin
                r_valid_bits <= '0;
                r_default    <= 1'b0;
                r_cursor     <= '0;
                r_out_valid  <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
        end
        if (i_cmd.mark_calc) begin
            r_mpos <= n_mpos;
            r_mok  <= n_mok;
        end
        if (i_cmd.mark_read) begin
            r_hit <= r_mok && (r_mpos < dbrt_pkg::MPOS_W'(r_size));
        end
        if (i_cmd.fetch_init) begin
            r_pos <= r_cursor;
        end
        if (i_cmd.scan_eval) begin
            if (o_status.run_end) begin
                r_run_start  <= dbrt_pkg::RUN_START_W'(run_start_pos);
                r_run_length <= dbrt_pkg::RUN_LENGTH_W'(end_pos - run_start_pos);
                r_done       <= 1'b0;
            end else if (!o_status.exhausted) begin
                r_pos <= next[POS_W-1:0];
                if (!r_in_run) begin
                    r_start <= run_start_pos;
                end
            end
        end
        if (i_cmd.clear_map) begin
            r_run_start  <= '0;
            r_run_length <= '0;
            r_done       <= 1'b1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_run_start  = r_run_start;
    assign o_run_length = r_run_length;
    assign o_done_res   = r_done;

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> r_run_start == '0 && r_run_length == '0)
        else $error("done result with nonzero run fields");

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_done |-> r_run_length != '0)
        else $error("empty run reported");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) <= 32'(MAX_BYTES))
        else $error("scan cursor beyond map");

endmodule

// ----- rtl/dirty_byte_run_tracker_core.sv -----
// Dirty byte run tracker top level. A mark steps through offset multiply, map read
// and map write before the next transfer is taken. A fetch keeps busy high through an
// init step, then one read and one evaluation per 8-bit map word scanned, plus a
// clear step when it answers done; the result strobe follows.
// Reset: every byte reads dirty, cursor zero, columns 128, pages 8; the receiver
// cannot stall results. Depends on dbrt_pkg, dbrt_regs, dbrt_ctrl, dbrt_datapath.
module dirty_byte_run_tracker_core #(
    parameter int MAX_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dbrt_pkg::KIND_W-1:0]         i_kind,
    input  logic [dbrt_pkg::COORD_W-1:0]        i_x_coord,
    input  logic [dbrt_pkg::COORD_W-1:0]        i_y_coord,
    output logic                                o_valid,
    output logic [dbrt_pkg::RUN_START_W-1:0]    o_run_start,
    output logic [dbrt_pkg::RUN_LENGTH_W-1:0]   o_run_length,
    output logic                                o_done_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dbrt_pkg::APB_AW-1:0]         paddr,
    input  logic [dbrt_pkg::APB_DW-1:0]         pwdata,
    output logic [dbrt_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    dbrt_pkg::t_cfg    cfg;
    dbrt_pkg::t_cmd    cmd;
    dbrt_pkg::t_status status;

    dbrt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dbrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    dbrt_datapath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_kind       (i_kind),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_run_start  (o_run_start),
        .o_run_length (o_run_length),
        .o_done_res   (o_done_res)
    );

endmodule

// ----- tb/dirty_byte_run_tracker_core_tb.sv -----
// Testbench for dirty_byte_run_tracker_core: directed and random marks and fetches,
// with a run predictor in a scoreboard class. Depends on dbrt_pkg and the core RTL.
module dirty_byte_run_tracker_core_tb;

    localparam int SCREEN_CAP  = 1024;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 117;
    localparam int SETTLE      = 8;
    localparam int TAIL_CYCLES = 300;
    localparam logic [dbrt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [dbrt_pkg::APB_AW-1:0] ADDR_COLUMNS = {dbrt_pkg::REG_COLUMNS, 2'b00};
    localparam logic [dbrt_pkg::APB_AW-1:0] ADDR_PAGES   = {dbrt_pkg::REG_PAGES, 2'b00};

    typedef struct {
        logic [dbrt_pkg::RUN_START_W-1:0]  run_start;
        logic [dbrt_pkg::RUN_LENGTH_W-1:0] run_length;
        logic                              done_res;
    } t_run_rec;

    class t_run_scoreboard;
        bit                                dirty[SCREEN_CAP];
        logic [dbrt_pkg::RUN_LENGTH_W-1:0] cursor;
        int unsigned                       cols;
        int unsigned                       pgs;
        t_run_rec                          pending_runs[$];
        int                                errors;
        int                                n_runs;
        int                                n_done;
        int                                n_items;

        function new();
            foreach (dirty[i]) dirty[i] = 1'b1;
            cursor  = '0;
            cols    = dbrt_pkg::COLUMNS_RESET;
            pgs     = dbrt_pkg::PAGES_RESET;
            errors  = 0;
            n_runs  = 0;
            n_done  = 0;
            n_items = 0;
        endfunction

        function void set_reg(logic idx, int unsigned val);
            if (idx == dbrt_pkg::REG_COLUMNS) cols = val & 'hFF;
            else pgs = val & 'hF;
        endfunction

        function int unsigned screen_bytes();
            int unsigned s;
            s = cols * pgs;
            return (s > SCREEN_CAP) ? SCREEN_CAP : s;
        endfunction

        function void mark_byte(int unsigned pos);
            if (pos < screen_bytes()) dirty[pos] = 1'b1;
        endfunction

        // Note one accepted transfer; return 1 if it had any effect.
        function bit note_input(logic [dbrt_pkg::KIND_W-1:0] kind, logic [7:0] x,
                                logic [7:0] y);
            int unsigned size;
            int unsigned s;
            int unsigned e;
            t_run_rec    rec;
            if (kind == dbrt_pkg::KIND_BYTE) begin
                if (x >= cols || y >= pgs) return 1'b0;
                mark_byte(y * cols + x);
                n_items++;
                return 1'b1;
            end
            if (kind == dbrt_pkg::KIND_PIXEL) begin
                if (x >= cols || y >= 8 * pgs) return 1'b0;
                mark_byte((y >> 3) * cols + x);
                n_items++;
                return 1'b1;
            end
            if (kind != dbrt_pkg::KIND_FETCH) return 1'b0;
            size = screen_bytes();
            s = cursor;
            while (s < size && !dirty[s]) s++;
            if (s >= size) begin
                // nothing left: clear the map and rewind
                foreach (dirty[i]) dirty[i] = 1'b0;
                cursor = '0;
                rec.run_start  = '0;
                rec.run_length = '0;
                rec.done_res   = 1'b1;
            end else begin
                e = s;
                while (e < size && dirty[e]) e++;
                cursor = e[dbrt_pkg::RUN_LENGTH_W-1:0];
                rec.run_start  = s[dbrt_pkg::RUN_START_W-1:0];
                rec.run_length = dbrt_pkg::RUN_LENGTH_W'(e - s);
                rec.done_res   = 1'b0;
            end
            pending_runs.push_back(rec);
            n_items++;
            return 1'b1;
        endfunction

        function void check_result(logic [dbrt_pkg::RUN_START_W-1:0] rs,
                                   logic [dbrt_pkg::RUN_LENGTH_W-1:0] rl, logic dn);
            t_run_rec want;
            if (pending_runs.size() == 0) begin
                $error("result with no fetch pending: run_start %0d run_length %0d done %0b",
                       rs, rl, dn);
                errors++;
                return;
            end
            want = pending_runs.pop_front();
            if (rs !== want.run_start) begin
                $error("run_start: expected %0d, got %0d", want.run_start, rs);
                errors++;
            end
            if (rl !== want.run_length) begin
                $error("run_length: expected %0d, got %0d", want.run_length, rl);
                errors++;
            end
            if (dn !== want.done_res) begin
                $error("done_res: expected %0b, got %0b", want.done_res, dn);
                errors++;
            end
            if (want.done_res) n_done++;
            else n_runs++;
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [dbrt_pkg::KIND_W-1:0]       i_kind;
    logic [dbrt_pkg::COORD_W-1:0]      i_x_coord;
    logic [dbrt_pkg::COORD_W-1:0]      i_y_coord;
    logic                              o_valid;
    logic [dbrt_pkg::RUN_START_W-1:0]  o_run_start;
    logic [dbrt_pkg::RUN_LENGTH_W-1:0] o_run_length;
    logic                              o_done_res;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [dbrt_pkg::APB_AW-1:0]       paddr;
    logic [dbrt_pkg::APB_DW-1:0]       pwdata;
    logic [dbrt_pkg::APB_DW-1:0]       prdata;
    logic                              pready;

    t_run_scoreboard sb = new();
    bit              no_idle = 1'b0;

    dirty_byte_run_tracker_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_valid      (o_valid),
        .o_run_start  (o_run_start),
        .o_run_length (o_run_length),
        .o_done_res   (o_done_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_run_start, o_run_length, o_done_res);
        end
    end

    initial begin
        #2_400_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Drive one item after a random gap and hold until the transfer.
    task automatic issue_item(logic [dbrt_pkg::KIND_W-1:0] kind, logic [7:0] x,
                              logic [7:0] y);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_kind    <= kind;
        i_x_coord <= x;
        i_y_coord <= y;
        do @(posedge i_clk); while (busy);
        void'(sb.note_input(kind, x, y));
    endtask

    // Drop start and hold until every expected run is back and the core is idle.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_runs.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [dbrt_pkg::APB_AW-1:0] addr,
                             logic [dbrt_pkg::APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(addr[2], data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [dbrt_pkg::APB_AW-1:0] addr, int unsigned want,
                                  int bits);
        logic [dbrt_pkg::APB_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if ((got & ((1 << bits) - 1)) !== want) begin
            $error("prdata: expected %0d, got %0d", want, got & ((1 << bits) - 1));
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int unsigned cfg_cols[PHASES] = '{1, 1, 128, 7, 0, 0, 0, 128};
        int unsigned cfg_pgs[PHASES]  = '{1, 8, 1, 3, 0, 0, 0, 8};
        int unsigned c;
        int unsigned p;
        int          counted;
        int          before_cnt;
        int          pick;
        int          len;
        int          x0;
        int          y0;
        logic [dbrt_pkg::KIND_W-1:0] k;

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_kind    = dbrt_pkg::KIND_BYTE;
        i_x_coord = '0;
        i_y_coord = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at reset geometry (128 x 8)
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);     // whole screen dirty after reset
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);     // cursor at end: done, map cleared
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);     // empty map: done again
        issue_item(dbrt_pkg::KIND_BYTE, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_BYTE, 8'd127, 8'd7);
        issue_item(dbrt_pkg::KIND_BYTE, 8'd128, 8'd0);    // off screen: column
        issue_item(dbrt_pkg::KIND_BYTE, 8'd0, 8'd8);      // off screen: page
        issue_item(dbrt_pkg::KIND_BYTE, 8'd255, 8'd255);
        issue_item(dbrt_pkg::KIND_PIXEL, 8'd5, 8'd63);
        issue_item(dbrt_pkg::KIND_PIXEL, 8'd6, 8'd7);
        issue_item(dbrt_pkg::KIND_PIXEL, 8'd7, 8'd0);
        issue_item(dbrt_pkg::KIND_PIXEL, 8'd0, 8'd64);    // off screen: row
        issue_item(KIND_UNUSED, 8'd1, 8'd1);
        drain();
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_BYTE, 8'd3, 8'd0);      // behind the cursor: lost at done
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);
        issue_item(dbrt_pkg::KIND_BYTE, 8'd170, 8'd85);
        issue_item(dbrt_pkg::KIND_PIXEL, 8'd85, 8'd170);
        issue_item(dbrt_pkg::KIND_BYTE, 8'd100, 8'd4);
        issue_item(dbrt_pkg::KIND_PIXEL, 8'd101, 8'd39);
        issue_item(dbrt_pkg::KIND_FETCH, 8'd0, 8'd0);     // leaves cursor mid-screen

        // random phases; the first shrinks the screen below the cursor
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            c = (cfg_cols[ph] != 0) ? cfg_cols[ph] : $urandom_range(1, 128);
            p = (cfg_pgs[ph] != 0) ? cfg_pgs[ph] : $urandom_range(1, 8);
            apb_write(ADDR_COLUMNS, c);
            apb_write(ADDR_PAGES, p);
            apb_read_check(ADDR_COLUMNS, c, dbrt_pkg::COL_W);
            apb_read_check(ADDR_PAGES, p, dbrt_pkg::PAGE_W);
            before_cnt = sb.n_items;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
                if ($urandom_range(0, 49) == 0) drain();
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // stroke of adjacent bytes on one page
                    len = $urandom_range(1, 8);
                    x0  = $urandom_range(0, c - 1);
                    if ($urandom_range(0, 1) == 0) begin
                        y0 = $urandom_range(0, p - 1);
                        k  = dbrt_pkg::KIND_BYTE;
                    end else begin
                        y0 = $urandom_range(0, 8 * p - 1);
                        k  = dbrt_pkg::KIND_PIXEL;
                    end
                    for (int i = 0; i < len && x0 + i < c; i++) begin
                        issue_item(k, 8'(x0 + i), 8'(y0));
                    end
                end else if (pick < 65) begin
                    repeat ($urandom_range(1, 3)) issue_item(dbrt_pkg::KIND_FETCH,
                                                             8'($urandom), 8'($urandom));
                end else if (pick < 75) begin
                    repeat ($urandom_range(4, 10)) issue_item(dbrt_pkg::KIND_FETCH,
                                                              8'($urandom), 8'($urandom));
                end else if (pick < 87) begin
                    issue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                end else if (pick < 94) begin
                    issue_item(dbrt_pkg::KIND_BYTE, 8'($urandom_range(0, c - 1)),
                               8'($urandom_range(0, p - 1)));
                end else begin
                    issue_item(dbrt_pkg::KIND_PIXEL, 8'($urandom_range(0, c - 1)),
                               8'($urandom_range(0, 8 * p - 1)));
                end
                counted = sb.n_items - before_cnt;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d effective transfers over %0d screen geometries", sb.n_items,
                 PHASES + 1);
        $display("checked %0d dirty runs and %0d done answers", sb.n_runs, sb.n_done);
        if (sb.errors == 0 && sb.pending_runs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dbrt_pkg.sv
rtl/dbrt_regs.sv
rtl/dbrt_ctrl.sv
rtl/dbrt_datapath.sv
rtl/dirty_byte_run_tracker_core.sv
tb/dirty_byte_run_tracker_core_tb.sv
